FILE: hw/rtl/tse_pkg.sv
// Shared types, codes and defaults for the turmite step engine.
package tse_pkg;

   localparam int unsigned GRID_SIDE_MAX_DEF = 256;
   localparam int unsigned RULE_SLOTS_DEF    = 16;

   // state codes at or above this limit are wildcard / keep codes
   localparam logic [8:0] STATE_LIM = 9'd16;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 21;

   localparam logic [CSR_AW-1:0] CSR_GRID_SIZE     = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_RULE_COUNT    = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_START_X       = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_START_Y       = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_START_HEADING = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_START_STATE   = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_STEP_BUDGET   = 3'd6;

   localparam logic [8:0]         GRID_SIZE_RST = 9'd256;
   localparam logic [1:0]         HEADING_RST   = 2'd1;
   localparam logic signed [20:0] BUDGET_RST    = -21'sd1;

   typedef enum logic [1:0] {
      REQ_TICK    = 2'd0,
      REQ_RULE    = 2'd1,
      REQ_CELL    = 2'd2,
      REQ_RESTART = 2'd3
   } req_kind_type;

   localparam logic [1:0] HEAD_NEG_X = 2'd0;
   localparam logic [1:0] HEAD_POS_Y = 2'd1;
   localparam logic [1:0] HEAD_POS_X = 2'd2;
   localparam logic [1:0] HEAD_NEG_Y = 2'd3;

   localparam logic [2:0] TURN_STRAIGHT = 3'b000;
   localparam logic [2:0] TURN_RIGHT    = 3'b001;
   localparam logic [2:0] TURN_BACK     = 3'b010;
   localparam logic [2:0] TURN_BACK_NEG = 3'b110;
   localparam logic [2:0] TURN_LEFT     = 3'b111;

   typedef struct packed {
      logic [4:0]        st;
      logic signed [4:0] col;
      logic signed [4:0] ncol;
      logic signed [2:0] turn;
      logic [4:0]        nst;
   } rule_type;

   localparam int RULE_W = $bits(rule_type);

   typedef struct packed {
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [1:0] heading;
      logic [3:0] machine_state;
      logic       rule_found;
      logic [3:0] matched_slot;
      logic [3:0] painted_color;
      logic       budget_done;
   } rsp_word_type;

endpackage

FILE: hw/rtl/tse_if.sv
// Request and response channel interfaces of the turmite step engine.
interface tse_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [3:0]        rule_slot;
   logic [4:0]        rule_state;
   logic signed [4:0] rule_color;
   logic signed [4:0] rule_new_color;
   logic signed [2:0] rule_turn;
   logic [4:0]        rule_next_state;
   logic [7:0]        cell_x;
   logic [7:0]        cell_y;
   logic [3:0]        cell_color;

   modport source (
      output valid, req_type, rule_slot, rule_state, rule_color, rule_new_color,
             rule_turn, rule_next_state, cell_x, cell_y, cell_color,
      input  ready
   );
   modport sink (
      input  valid, req_type, rule_slot, rule_state, rule_color, rule_new_color,
             rule_turn, rule_next_state, cell_x, cell_y, cell_color,
      output ready
   );
endinterface

interface tse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pos_x;
   logic [7:0] pos_y;
   logic [1:0] heading;
   logic [3:0] machine_state;
   logic       rule_found;
   logic [3:0] matched_slot;
   logic [3:0] painted_color;
   logic       budget_done;

   modport source (
      output valid, pos_x, pos_y, heading, machine_state, rule_found, matched_slot,
             painted_color, budget_done,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, heading, machine_state, rule_found, matched_slot,
             painted_color, budget_done,
      output ready
   );
endinterface

FILE: hw/rtl/turmite_step_engine_unit.sv
// Turmite step engine: rule scan sequencer, grid and rule memories, walker state.
// Tick: ST_MODX, ST_MODY (qx, qy wrap reductions, 0 when GRID_SIDE_MAX >= 256), ST_GRD,
// ST_SCAN over k slots (1..RULE_SLOTS, one rule read per cycle), then ST_RESP.
// Cell write: ST_MODX, ST_MODY, ST_RESP. Rule write, restart, blocked tick: ST_RESP only.
// A request is taken only in ST_IDLE; a held result stalls the next word in ST_RESP.
// Reset starts a wipe of all GRID_DEPTH grid words; input is not ready until done.
module turmite_step_engine_unit import tse_pkg::*; #(
   parameter int unsigned GRID_SIDE_MAX = GRID_SIDE_MAX_DEF,
   parameter int unsigned RULE_SLOTS    = RULE_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   tse_req_if.sink           req_ch,
   tse_rsp_if.source         rsp_ch,
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int unsigned SIZE_CAP = (GRID_SIDE_MAX < 511) ? GRID_SIDE_MAX : 511;
   localparam int CW  = $clog2((SIZE_CAP > 256) ? SIZE_CAP : 256);
   localparam int AC  = $clog2(GRID_SIDE_MAX);
   localparam int GAW = 2 * AC;
   localparam int GRID_DEPTH = 2 ** GAW;
   localparam int MW  = ($clog2(GRID_SIDE_MAX + 1) > CW) ? $clog2(GRID_SIDE_MAX + 1) : CW;
   localparam int SW  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam logic [8:0] SIZE_CAP_W = 9'(SIZE_CAP);
   localparam logic [8:0] SLOT_LIM   = 9'(RULE_SLOTS);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_MODX, ST_MODY, ST_GRD, ST_SCAN, ST_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [GAW-1:0]    clr_ff, clr_in;
   req_kind_type      op_ff, op_in;
   logic [CW-1:0]     mod_ff, mod_in;
   logic [AC-1:0]     ax_ff, ax_in, ay_ff, ay_in;
   logic [7:0]        cy_ff, cy_in;
   logic [3:0]        ccol_ff, ccol_in;
   logic [4:0]        chk_idx_ff, chk_idx_in;
   logic [CW-1:0]     cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [1:0]        cur_heading_ff, cur_heading_in;
   logic [3:0]        cur_state_ff, cur_state_in;
   logic [3:0]        last_slot_ff, last_slot_in;
   logic signed [20:0] budget_ff, budget_in;
   logic              found_ff, found_in;
   logic [3:0]        painted_ff, painted_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      out_ff, out_in;

   logic [8:0]        grid_size_ff, grid_size_in;
   logic [4:0]        rule_count_ff, rule_count_in;
   logic [7:0]        start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [1:0]        start_heading_ff, start_heading_in;
   logic [3:0]        start_state_ff, start_state_in;
   logic signed [20:0] step_budget_ff, step_budget_in;

   logic              grid_we;
   logic [GAW-1:0]    grid_waddr;
   logic [3:0]        grid_wdata;
   logic [3:0]        grid_rdata;
   logic              rule_we;
   logic [SW-1:0]     rule_raddr;
   logic [RULE_W-1:0] rule_rdata;
   rule_type          rule_wword;
   rule_type          rule_q;

   logic              req_fire;
   logic              out_free;
   logic              mod_ge;
   logic [CW-1:0]     mod_sub;
   logic [8:0]        n_eff;
   logic [4:0]        scan_cnt;
   logic              st_ok, col_ok, in_range, hit, last_slot_hit, end_scan;
   logic [1:0]        turned;
   logic              do_move;
   logic [CW-1:0]     moved_x, moved_y;

   function automatic logic [CW-1:0] step_up(input logic [CW-1:0] v, input logic [8:0] n);
      logic [9:0] lim;
      lim = 10'(n) - 10'd1;
      if (10'(v) >= lim) begin
         step_up = '0;
      end else begin
         step_up = v + CW'(1);
      end
   endfunction

   function automatic logic [CW-1:0] step_down(input logic [CW-1:0] v, input logic [8:0] n);
      if (v == '0) begin
         step_down = CW'(n - 9'd1);
      end else begin
         step_down = v - CW'(1);
      end
   endfunction

   tse_ram #(.WIDTH(4), .DEPTH(GRID_DEPTH), .AW(GAW)) u_grid (
      .clock   (clock),
      .wr_en   (grid_we),
      .wr_addr (grid_waddr),
      .wr_data (grid_wdata),
      .rd_addr ({ax_ff, ay_ff}),
      .rd_data (grid_rdata)
   );

   tse_ram #(.WIDTH(RULE_W), .DEPTH(RULE_SLOTS), .AW(SW)) u_rules (
      .clock   (clock),
      .wr_en   (rule_we),
      .wr_addr (SW'(req_ch.rule_slot)),
      .wr_data (rule_wword),
      .rd_addr (rule_raddr),
      .rd_data (rule_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rule_wword.st   = req_ch.rule_state;
   assign rule_wword.col  = req_ch.rule_color;
   assign rule_wword.ncol = req_ch.rule_new_color;
   assign rule_wword.turn = req_ch.rule_turn;
   assign rule_wword.nst  = req_ch.rule_next_state;
   assign rule_q          = rule_type'(rule_rdata);

   // speculatively fetch the next slot while the current one is checked
   assign rule_raddr = (state_ff == ST_SCAN) ? SW'(chk_idx_ff + 5'd1) : '0;

   // shared wrap reducer: subtract GRID_SIDE_MAX until the coordinate fits
   assign mod_ge  = MW'(mod_ff) >= MW'(GRID_SIDE_MAX);
   assign mod_sub = CW'(MW'(mod_ff) - MW'(GRID_SIDE_MAX));

   assign n_eff = (grid_size_ff == '0) ? 9'd1 :
                  ((grid_size_ff > SIZE_CAP_W) ? SIZE_CAP_W : grid_size_ff);
   assign scan_cnt = (9'(rule_count_ff) > SLOT_LIM) ? 5'(SLOT_LIM) : rule_count_ff;

   // rule compare for the slot whose word sits on the read port
   assign st_ok    = (9'(rule_q.st) >= STATE_LIM) || (rule_q.st == {1'b0, cur_state_ff});
   assign col_ok   = rule_q.col[4] || (rule_q.col[3:0] == grid_rdata);
   assign in_range = chk_idx_ff < scan_cnt;
   assign hit      = in_range && st_ok && col_ok;
   assign last_slot_hit = ({1'b0, chk_idx_ff} + 6'd1) >= {1'b0, scan_cnt};
   assign end_scan = hit || last_slot_hit;

   always_comb begin
      do_move = 1'b1;
      case (rule_q.turn) inside
         TURN_LEFT:                turned = cur_heading_ff + 2'd3;
         TURN_STRAIGHT:            turned = cur_heading_ff;
         TURN_RIGHT:               turned = cur_heading_ff + 2'd1;
         TURN_BACK, TURN_BACK_NEG: turned = cur_heading_ff + 2'd2;
         default: begin
            turned  = cur_heading_ff;
            do_move = 1'b0;
         end
      endcase
   end

   always_comb begin
      moved_x = cur_x_ff;
      moved_y = cur_y_ff;
      case (turned)
         HEAD_NEG_X: moved_x = step_down(cur_x_ff, n_eff);
         HEAD_POS_Y: moved_y = step_up(cur_y_ff, n_eff);
         HEAD_POS_X: moved_x = step_up(cur_x_ff, n_eff);
         default:    moved_y = step_down(cur_y_ff, n_eff);
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      op_in          = op_ff;
      mod_in         = mod_ff;
      ax_in          = ax_ff;
      ay_in          = ay_ff;
      cy_in          = cy_ff;
      ccol_in        = ccol_ff;
      chk_idx_in     = chk_idx_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      cur_heading_in = cur_heading_ff;
      cur_state_in   = cur_state_ff;
      last_slot_in   = last_slot_ff;
      budget_in      = budget_ff;
      found_in       = found_ff;
      painted_in     = painted_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      out_in         = out_ff;
      grid_we        = 1'b0;
      grid_waddr     = {ax_ff, ay_ff};
      grid_wdata     = ccol_ff;
      rule_we        = 1'b0;

      grid_size_in     = grid_size_ff;
      rule_count_in    = rule_count_ff;
      start_x_in       = start_x_ff;
      start_y_in       = start_y_ff;
      start_heading_in = start_heading_ff;
      start_state_in   = start_state_ff;
      step_budget_in   = step_budget_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_SIZE:     grid_size_in     = csr_wdata[8:0];
            CSR_RULE_COUNT:    rule_count_in    = csr_wdata[4:0];
            CSR_START_X:       start_x_in       = csr_wdata[7:0];
            CSR_START_Y:       start_y_in       = csr_wdata[7:0];
            CSR_START_HEADING: start_heading_in = csr_wdata[1:0];
            CSR_START_STATE:   start_state_in   = csr_wdata[3:0];
            CSR_STEP_BUDGET:   step_budget_in   = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            grid_we    = 1'b1;
            grid_waddr = clr_ff;
            grid_wdata = '0;
            clr_in     = clr_ff + GAW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               found_in   = 1'b0;
               painted_in = '0;
               op_in      = req_kind_type'(req_ch.req_type);
               unique case (req_kind_type'(req_ch.req_type))
                  REQ_TICK: begin
                     if (budget_ff == '0) begin
                        state_in = ST_RESP;
                     end else begin
                        mod_in   = cur_x_ff;
                        state_in = ST_MODX;
                     end
                  end
                  REQ_RULE: begin
                     // drop writes to slots that do not exist
                     rule_we  = 9'(req_ch.rule_slot) < SLOT_LIM;
                     state_in = ST_RESP;
                  end
                  REQ_CELL: begin
                     mod_in   = CW'(req_ch.cell_x);
                     cy_in    = req_ch.cell_y;
                     ccol_in  = req_ch.cell_color;
                     state_in = ST_MODX;
                  end
                  REQ_RESTART: begin
                     cur_x_in       = CW'(start_x_ff);
                     cur_y_in       = CW'(start_y_ff);
                     cur_heading_in = start_heading_ff;
                     cur_state_in   = start_state_ff;
                     budget_in      = step_budget_ff;
                     last_slot_in   = '0;
                     state_in       = ST_RESP;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_MODX: begin
            if (mod_ge) begin
               mod_in = mod_sub;
            end else begin
               ax_in    = AC'(mod_ff);
               mod_in   = (op_ff == REQ_TICK) ? cur_y_ff : CW'(cy_ff);
               state_in = ST_MODY;
            end
         end
         ST_MODY: begin
            if (mod_ge) begin
               mod_in = mod_sub;
            end else begin
               ay_in = AC'(mod_ff);
               if (op_ff == REQ_CELL) begin
                  grid_we    = 1'b1;
                  grid_waddr = {ax_ff, AC'(mod_ff)};
                  state_in   = ST_RESP;
               end else begin
                  state_in = ST_GRD;
               end
            end
         end
         ST_GRD: begin
            chk_idx_in = '0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (!end_scan) begin
               chk_idx_in = chk_idx_ff + 5'd1;
            end else begin
               painted_in = grid_rdata;
               if (hit) begin
                  found_in     = 1'b1;
                  last_slot_in = chk_idx_ff[3:0];
                  if (!rule_q.ncol[4]) begin
                     grid_we    = 1'b1;
                     grid_wdata = rule_q.ncol[3:0];
                     painted_in = rule_q.ncol[3:0];
                  end
                  if (do_move) begin
                     cur_heading_in = turned;
                     cur_x_in       = moved_x;
                     cur_y_in       = moved_y;
                  end
                  if (9'(rule_q.nst) < STATE_LIM) begin
                     cur_state_in = rule_q.nst[3:0];
                  end
               end
               // negative budgets never count down
               if (!budget_ff[20] && budget_ff != '0) begin
                  budget_in = budget_ff - 21'sd1;
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               out_in.pos_x         = cur_x_ff[7:0];
               out_in.pos_y         = cur_y_ff[7:0];
               out_in.heading       = cur_heading_ff;
               out_in.machine_state = cur_state_ff;
               out_in.rule_found    = found_ff;
               out_in.matched_slot  = last_slot_ff;
               out_in.painted_color = painted_ff;
               out_in.budget_done   = (budget_ff == '0);
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         cur_x_ff         <= '0;
         cur_y_ff         <= '0;
         cur_heading_ff   <= HEADING_RST;
         cur_state_ff     <= '0;
         last_slot_ff     <= '0;
         budget_ff        <= BUDGET_RST;
         grid_size_ff     <= GRID_SIZE_RST;
         rule_count_ff    <= '0;
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         start_heading_ff <= HEADING_RST;
         start_state_ff   <= '0;
         step_budget_ff   <= BUDGET_RST;
      end else begin
         state_ff         <= state_in;
         clr_ff           <= clr_in;
         rsp_valid_ff     <= rsp_valid_in;
         cur_x_ff         <= cur_x_in;
         cur_y_ff         <= cur_y_in;
         cur_heading_ff   <= cur_heading_in;
         cur_state_ff     <= cur_state_in;
         last_slot_ff     <= last_slot_in;
         budget_ff        <= budget_in;
         grid_size_ff     <= grid_size_in;
         rule_count_ff    <= rule_count_in;
         start_x_ff       <= start_x_in;
         start_y_ff       <= start_y_in;
         start_heading_ff <= start_heading_in;
         start_state_ff   <= start_state_in;
         step_budget_ff   <= step_budget_in;
      end
      op_ff      <= op_in;
      mod_ff     <= mod_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      cy_ff      <= cy_in;
      ccol_ff    <= ccol_in;
      chk_idx_ff <= chk_idx_in;
      found_ff   <= found_in;
      painted_ff <= painted_in;
      out_ff     <= out_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.pos_x         = out_ff.pos_x;
   assign rsp_ch.pos_y         = out_ff.pos_y;
   assign rsp_ch.heading       = out_ff.heading;
   assign rsp_ch.machine_state = out_ff.machine_state;
   assign rsp_ch.rule_found    = out_ff.rule_found;
   assign rsp_ch.matched_slot  = out_ff.matched_slot;
   assign rsp_ch.painted_color = out_ff.painted_color;
   assign rsp_ch.budget_done   = out_ff.budget_done;

`ifndef SYNTH
   a_resp_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished word not loaded into output register");

   a_no_stale_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ch.ready) |=> (!rsp_valid_ff || $past(state_ff == ST_RESP)))
      else $error("output word repeated after it was taken");

   a_unlimited_budget: assert property (@(posedge clock) disable iff (reset)
      (budget_ff[20] && !(req_fire && req_ch.req_type == REQ_RESTART))
      |=> (budget_ff == $past(budget_ff)))
      else $error("unlimited budget changed without restart");

   a_heading_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && cur_heading_ff != $past(cur_heading_ff))
      |-> $past(state_ff == ST_SCAN || (req_fire && req_ch.req_type == REQ_RESTART)))
      else $error("heading changed outside a tick or restart");
`endif

endmodule

FILE: hw/rtl/tse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
